// File: src/caled_pkg.sv
// Shared types and constants for the channel activity LED state block.
// No dependencies; every other file imports this package.
package caled_pkg;

	// Fixed field widths
	localparam int unsigned CH_W    = 4;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned MASK_W  = 7;
	localparam int unsigned CFG_W   = 32;

	// Channel 5 may run as a DAC; it then uses enable bit 6 instead of bit 5
	localparam logic [CH_W-1:0] DAC_CHANNEL = 4'd5;
	localparam int unsigned DAC_EN_BIT = 6;
	localparam int unsigned CH5_EN_BIT = 5;

	// Register reset values
	localparam logic [MASK_W-1:0]  MASK_RST        = 7'd127;
	localparam logic [TIME_W-1:0]  HOLD_RST        = 32'd12000000;
	localparam logic [LEVEL_W-1:0] BRIGHT_LVL_RST  = 8'd255;
	localparam logic [LEVEL_W-1:0] ON_LVL_RST      = 8'd96;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE_MASK = 2'd0,
		REG_BRIGHT_HOLD = 2'd1,
		REG_BRIGHT_LVL  = 2'd2,
		REG_ON_LVL      = 2'd3
	} cfg_reg_t;

	// Per-channel LED mode
	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ON     = 2'd1,
		MODE_BRIGHT = 2'd2,
		MODE_PERMA  = 2'd3
	} led_mode_t;

	// One captured scan
	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              key_on;
		logic              key_on_pulse;
		logic              param_pulse;
		logic              fixed_on;
		logic              dac_mode;
		logic [TIME_W-1:0] now;
	} scan_t;

	// Configuration register set
	typedef struct packed {
		logic [MASK_W-1:0]  enable_mask;
		logic [TIME_W-1:0]  bright_hold;
		logic [LEVEL_W-1:0] bright_level;
		logic [LEVEL_W-1:0] on_level;
	} cfg_t;

	// Decision for one scan: state update and drive level
	typedef struct packed {
		logic               wr_mode;
		logic               restart;
		led_mode_t          mode;
		logic [LEVEL_W-1:0] level;
	} upd_t;

endpackage

// File: src/caled_scan_if.sv
// Scan channel: valid/ready handshake carrying one channel scan.
// Depends on caled_pkg for field widths.
interface caled_scan_if import caled_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   channel;
	logic              key_on;
	logic              key_on_pulse;
	logic              param_pulse;
	logic              fixed_on;
	logic              dac_mode;
	logic [TIME_W-1:0] now;

	modport source (output valid, channel, key_on, key_on_pulse, param_pulse, fixed_on,
		dac_mode, now, input ready);
	modport sink (input valid, channel, key_on, key_on_pulse, param_pulse, fixed_on,
		dac_mode, now, output ready);
endinterface

// File: src/caled_level_if.sv
// Level channel: valid/ready handshake carrying one channel brightness.
// Depends on caled_pkg for field widths.
interface caled_level_if import caled_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    channel_out;
	logic [LEVEL_W-1:0] brightness;

	modport source (output valid, channel_out, brightness, input ready);
	modport sink (input valid, channel_out, brightness, output ready);
endinterface

// File: src/channel_activity_led_state.sv
// Top level of the channel activity LED state block.
// Depends on caled_pkg, caled_scan_if, caled_level_if and caled_update.
//
// Usage:
//   scan  : sink channel, one scan of one sound channel per transfer.
//   level : source channel, one brightness per scan, in scan order.
//   cfg_we/cfg_index/cfg_data : register writes, taken at any clock edge
//           with cfg_we high; write only while no scan is in flight.
// Path: an accepted scan passes the input register, then the result
//   register, from which it is presented on level.
// Throughput: one scan per cycle while level takes results. Each
//   channel's mode and bright start time live in flip-flops; the scan in
//   the input register reads its channel's entry, decides, and writes it
//   back in the same cycle, so a scan of the same channel right behind
//   sees the updated entry.
// Stall: when level is not taken, the result holds; the input register
//   still fills, and scan.ready drops only when both stages are full.
// Reset: all channels off with zero start time, registers at defaults,
//   both stages empty.
module channel_activity_led_state import caled_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	caled_scan_if.sink         scan,
	caled_level_if.source      level,
	input  logic               cfg_we,
	input  cfg_reg_t           cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = $clog2(NUM_CHANNELS);

	cfg_t               cfg_q;
	scan_t              scan_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic [CH_W-1:0]    channel_s2;
	logic [LEVEL_W-1:0] level_s2;
	led_mode_t          mode_q  [NUM_CHANNELS];
	logic [TIME_W-1:0]  start_q [NUM_CHANNELS];
	logic               adv_s1;
	logic               in_range;
	logic [IDX_W-1:0]   idx;
	upd_t               upd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask  <= MASK_RST;
			cfg_q.bright_hold  <= HOLD_RST;
			cfg_q.bright_level <= BRIGHT_LVL_RST;
			cfg_q.on_level     <= ON_LVL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE_MASK: cfg_q.enable_mask  <= cfg_data[MASK_W-1:0];
				REG_BRIGHT_HOLD: cfg_q.bright_hold  <= cfg_data[TIME_W-1:0];
				REG_BRIGHT_LVL:  cfg_q.bright_level <= cfg_data[LEVEL_W-1:0];
				REG_ON_LVL:      cfg_q.on_level     <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control
	assign adv_s1     = valid_s1 & (~valid_s2 | level.ready);
	assign scan.ready = ~valid_s1 | adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			scan_s1.channel      <= scan.channel;
			scan_s1.key_on       <= scan.key_on;
			scan_s1.key_on_pulse <= scan.key_on_pulse;
			scan_s1.param_pulse  <= scan.param_pulse;
			scan_s1.fixed_on     <= scan.fixed_on;
			scan_s1.dac_mode     <= scan.dac_mode;
			scan_s1.now          <= scan.now;
		end
	end

	// Channel table lookup
	assign in_range = ({1'b0, scan_s1.channel} < (CH_W+1)'(NUM_CHANNELS));
	assign idx      = scan_s1.channel[IDX_W-1:0];

	caled_update u_update (
		.scan      (scan_s1),
		.in_range  (in_range),
		.cur_mode  (mode_q[idx]),
		.cur_start (start_q[idx]),
		.cfg       (cfg_q),
		.upd       (upd)
	);

	// Channel table write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				mode_q[i]  <= MODE_OFF;
				start_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (upd.wr_mode) begin
				mode_q[idx] <= upd.mode;
			end
			if (upd.restart) begin
				start_q[idx] <= scan_s1.now;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | level.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			channel_s2 <= scan_s1.channel;
			level_s2   <= upd.level;
		end
	end

	assign level.valid       = valid_s2;
	assign level.channel_out = channel_s2;
	assign level.brightness  = level_s2;

endmodule

// File: src/caled_update.sv
// Next-mode and brightness decision for one scan, purely combinational.
// Depends on caled_pkg.
module caled_update import caled_pkg::*; (
	input  scan_t              scan,
	input  logic               in_range,
	input  led_mode_t          cur_mode,
	input  logic [TIME_W-1:0]  cur_start,
	input  cfg_t               cfg,
	output upd_t               upd
);

	logic [TIME_W-1:0] elapsed;
	logic              expired;
	logic              restart;
	logic              enabled;
	led_mode_t         aged_mode;
	led_mode_t         next_mode;

	// Hold check uses wrapping difference
	assign elapsed = scan.now - cur_start;
	assign expired = (elapsed >= cfg.bright_hold);
	assign restart = scan.key_on_pulse | (scan.param_pulse & scan.key_on);

	// Mode update, in priority order
	always_comb begin
		aged_mode = cur_mode;
		if (cur_mode == MODE_BRIGHT && expired) begin
			aged_mode = MODE_ON;
		end
		priority if (restart) begin
			next_mode = MODE_BRIGHT;
		end else if (scan.fixed_on) begin
			next_mode = MODE_PERMA;
		end else if (!scan.key_on) begin
			next_mode = MODE_OFF;
		end else begin
			next_mode = aged_mode;
		end
		// DAC forces plain on for channel 5
		if (scan.channel == DAC_CHANNEL && scan.dac_mode) begin
			next_mode = MODE_ON;
		end
	end

	// Enable gating: 0-4 own bit, 5 bit 5 or 6, higher never gated
	always_comb begin
		if (scan.channel < DAC_CHANNEL) begin
			enabled = cfg.enable_mask[scan.channel[2:0]];
		end else if (scan.channel == DAC_CHANNEL) begin
			enabled = scan.dac_mode ? cfg.enable_mask[DAC_EN_BIT]
				: cfg.enable_mask[CH5_EN_BIT];
		end else begin
			enabled = 1'b1;
		end
	end

	// Brightness select
	always_comb begin
		upd.wr_mode = in_range;
		upd.restart = in_range & restart;
		upd.mode    = next_mode;
		upd.level   = '0;
		if (in_range && enabled) begin
			unique case (next_mode)
				MODE_BRIGHT, MODE_PERMA: upd.level = cfg.bright_level;
				MODE_ON:                 upd.level = cfg.on_level;
				default:                 upd.level = '0;
			endcase
		end
	end

endmodule

// File: src/caled_checker.sv
// Port-level checks for channel_activity_led_state, attached by bind.
// Depends on caled_pkg for field widths.
module caled_checker import caled_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 10
) (
	input logic               clk,
	input logic               arst_n,
	input logic               scan_valid,
	input logic               scan_ready,
	input logic [CH_W-1:0]    scan_channel,
	input logic               level_valid,
	input logic               level_ready,
	input logic [CH_W-1:0]    level_channel,
	input logic [LEVEL_W-1:0] level_brightness
);

	logic scan_xfer;
	assign scan_xfer = scan_valid & scan_ready;

	// A stalled result holds
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid && !level_ready |=> level_valid && $stable(level_channel)
			&& $stable(level_brightness))
		else $error("level payload changed while stalled");

	// Scans always flow while the result stage is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!level_valid |-> scan_ready)
		else $error("scan stalled with empty result stage");

	// Channels beyond the table are always dark
	a_out_of_range_dark: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid && ({1'b0, level_channel} >= (CH_W+1)'(NUM_CHANNELS))
			|-> level_brightness == '0)
		else $error("out-of-range channel lit");

	// A scan reaches level through the input and result registers when the receiver takes results
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		scan_xfer ##1 level_ready |=> level_valid
			&& level_channel == $past(scan_channel, 2))
		else $error("scan result missing after two cycles");

endmodule

bind channel_activity_led_state caled_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_caled_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.scan_valid       (scan.valid),
	.scan_ready       (scan.ready),
	.scan_channel     (scan.channel),
	.level_valid      (level.valid),
	.level_ready      (level.ready),
	.level_channel    (level.channel_out),
	.level_brightness (level.brightness)
);

// File: test/channel_activity_led_state_tb.sv
// Self-checking testbench for the channel activity LED state block.
// Depends on caled_pkg, caled_scan_if, caled_level_if and the block's RTL.
// Scans go in through a directed table and then random phases; every brightness is checked.
`timescale 1ns / 100ps

module channel_activity_led_state_tb;
	import caled_pkg::*;

	localparam int unsigned NCH        = 10;
	localparam int unsigned PHASES     = 8;
	localparam int unsigned PH_ITEMS   = 166;
	localparam int unsigned LONG_STALL = 300;
	localparam int unsigned LIMIT      = 400000;
	localparam int unsigned MAX_SHOWN  = 10;

	// One brightness waiting to come out
	typedef struct {
		logic [CH_W-1:0]    ch;
		logic [LEVEL_W-1:0] lvl;
	} level_exp_t;

	// One line of the directed table: a register write or a scan
	typedef struct {
		bit                 is_cfg;
		cfg_reg_t           idx;
		logic [CFG_W-1:0]   data;
		scan_t              s;
		bit                 chk;
		logic [LEVEL_W-1:0] lvl;
	} stim_row_t;

	// Register settings of the random phases, extremes among them
	logic [MASK_W-1:0]  ph_mask [PHASES] = '{7'd127, 7'd0, 7'd64, 7'd32,
		7'h55, 7'h2A, 7'd127, 7'd31};
	logic [TIME_W-1:0]  ph_hold [PHASES] = '{32'd12000000, 32'd0, 32'hFFFF_FFFF,
		32'd50, 32'd1, 32'd3000, 32'd7, 32'h8000_0000};
	logic [LEVEL_W-1:0] ph_bright [PHASES] = '{8'd255, 8'd0, 8'd255, 8'd200,
		8'hAA, 8'h55, 8'd1, 8'd128};
	logic [LEVEL_W-1:0] ph_on [PHASES] = '{8'd96, 8'd0, 8'd255, 8'd17,
		8'h55, 8'hAA, 8'd254, 8'd0};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	caled_scan_if  scan_ch ();
	caled_level_if level_ch ();

	channel_activity_led_state #(
		.NUM_CHANNELS(NCH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan_ch),
		.level    (level_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the per-channel LED state and the registers
	led_mode_t          mode_tbl [NCH];
	logic [TIME_W-1:0]  start_tbl [NCH];
	logic [MASK_W-1:0]  mask_cfg;
	logic [TIME_W-1:0]  hold_cfg;
	logic [LEVEL_W-1:0] bright_cfg;
	logic [LEVEL_W-1:0] on_cfg;

	level_exp_t pending_levels [$];
	int unsigned err_cnt;
	int unsigned cycles;
	logic [TIME_W-1:0] stamp;
	bit tx_no_idle;
	bit rx_no_idle;
	bit long_stall_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Brightness for one scan; updates the shadow state
	function automatic logic [LEVEL_W-1:0] scan_brightness(input scan_t s);
		led_mode_t m;
		logic en;
		logic [LEVEL_W-1:0] lvl;
		if (s.channel >= NCH)
			return '0;
		m = mode_tbl[s.channel];
		// hold check with wrapping difference
		if (m == MODE_BRIGHT && (s.now - start_tbl[s.channel]) >= hold_cfg)
			m = MODE_ON;
		if (s.key_on_pulse || (s.param_pulse && s.key_on)) begin
			start_tbl[s.channel] = s.now;
			m = MODE_BRIGHT;
		end else if (s.fixed_on) begin
			m = MODE_PERMA;
		end else if (!s.key_on) begin
			m = MODE_OFF;
		end
		if (s.channel == DAC_CHANNEL && s.dac_mode)
			m = MODE_ON;
		mode_tbl[s.channel] = m;
		// gating: 0..4 own bit, 5 picks bit 5 or 6, square channels always on
		if (s.channel < DAC_CHANNEL)
			en = mask_cfg[s.channel[2:0]];
		else if (s.channel == DAC_CHANNEL)
			en = s.dac_mode ? mask_cfg[DAC_EN_BIT] : mask_cfg[CH5_EN_BIT];
		else
			en = 1'b1;
		lvl = '0;
		if (en) begin
			if (m == MODE_BRIGHT || m == MODE_PERMA)
				lvl = bright_cfg;
			else if (m == MODE_ON)
				lvl = on_cfg;
		end
		return lvl;
	endfunction

	function automatic stim_row_t scan_row(input logic [CH_W-1:0] ch, input bit kon,
			input bit kp, input bit pp, input bit fx, input bit dac,
			input logic [TIME_W-1:0] now, input bit chk, input logic [LEVEL_W-1:0] lvl);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_ENABLE_MASK;
		r.data = '0;
		r.s.channel = ch;
		r.s.key_on = kon;
		r.s.key_on_pulse = kp;
		r.s.param_pulse = pp;
		r.s.fixed_on = fx;
		r.s.dac_mode = dac;
		r.s.now = now;
		r.chk = chk;
		r.lvl = lvl;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		stim_row_t r;
		r = scan_row('0, 0, 0, 0, 0, 0, '0, 0, '0);
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// Register write; caller sits at a falling edge with nothing in flight
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_ENABLE_MASK: mask_cfg = data[MASK_W-1:0];
			REG_BRIGHT_HOLD: hold_cfg = data[TIME_W-1:0];
			REG_BRIGHT_LVL:  bright_cfg = data[LEVEL_W-1:0];
			REG_ON_LVL:      on_cfg = data[LEVEL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Stop offering scans until every brightness has come back
	task automatic settle();
		scan_ch.valid = 1'b0;
		while (pending_levels.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Offer one scan and record its expected brightness on transfer
	task automatic send_scan(input scan_t s, input bit chk, input logic [LEVEL_W-1:0] lvl);
		int unsigned gap;
		level_exp_t want;
		logic [LEVEL_W-1:0] pred;
		gap = tx_no_idle ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			scan_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_ch.channel = s.channel;
		scan_ch.key_on = s.key_on;
		scan_ch.key_on_pulse = s.key_on_pulse;
		scan_ch.param_pulse = s.param_pulse;
		scan_ch.fixed_on = s.fixed_on;
		scan_ch.dac_mode = s.dac_mode;
		scan_ch.now = s.now;
		scan_ch.valid = 1'b1;
		do @(posedge clk); while (!scan_ch.ready);
		pred = scan_brightness(s);
		want.ch = s.channel;
		want.lvl = chk ? lvl : pred;
		pending_levels.push_back(want);
		@(negedge clk);
	endtask

	// Random scan: mostly valid channels, time moving at a pace scaled to the hold
	task automatic make_scan(output scan_t s);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			s.channel = CH_W'($urandom_range(NCH, 15));
		else if (r < 25)
			s.channel = DAC_CHANNEL;
		else
			s.channel = CH_W'($urandom_range(0, NCH - 1));
		s.key_on = ($urandom_range(0, 9) < 7);
		s.key_on_pulse = ($urandom_range(0, 9) < 2);
		s.param_pulse = ($urandom_range(0, 9) < 2);
		s.fixed_on = ($urandom_range(0, 9) == 0);
		s.dac_mode = ($urandom_range(0, 9) < 3);
		if ($urandom_range(0, 19) == 0)
			stamp = $urandom();
		else
			stamp = stamp + $urandom_range(0, (hold_cfg >> 2) + 3);
		s.now = stamp;
		// land right on the hold boundary of a bright channel now and then
		if (s.channel < NCH && mode_tbl[s.channel] == MODE_BRIGHT
				&& $urandom_range(0, 9) == 0)
			s.now = start_tbl[s.channel] + hold_cfg - $urandom_range(0, 1);
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin : level_sink
		int unsigned stall;
		level_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				level_ch.ready = 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_req = 1'b0;
			end
			stall = rx_no_idle ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				level_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			level_ch.ready = 1'b1;
			do @(posedge clk); while (!level_ch.valid);
		end
	end

	// Compare each brightness transfer with the oldest expectation; watchdog
	always @(posedge clk) begin
		level_exp_t want;
		if (arst_n && level_ch.valid && level_ch.ready) begin
			if (pending_levels.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("unexpected transfer: ch %0d brightness %0d",
						level_ch.channel_out, level_ch.brightness);
			end else begin
				want = pending_levels.pop_front();
				if (level_ch.channel_out !== want.ch || level_ch.brightness !== want.lvl) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display("mismatch: exp ch %0d brightness %0d, got ch %0d brightness %0d",
							want.ch, want.lvl, level_ch.channel_out, level_ch.brightness);
				end
			end
		end
		cycles++;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin : stimulus
		stim_row_t directed [$];
		scan_t s;
		directed.push_back(scan_row(4'd0, 0, 0, 0, 0, 0, 32'd0, 1, 8'd0));
		directed.push_back(scan_row(4'd0, 1, 1, 0, 0, 0, 32'd100, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd0, 1, 0, 0, 0, 0, 32'd200, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd0, 1, 0, 0, 0, 0, 32'd12000100, 1, ON_LVL_RST));
		directed.push_back(scan_row(4'd0, 0, 0, 0, 0, 0, 32'd12000200, 1, 8'd0));
		directed.push_back(scan_row(4'd1, 0, 0, 0, 1, 0, 32'd5, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd1, 1, 0, 0, 0, 0, 32'd6, 1, BRIGHT_LVL_RST));
		// bright start just below the wrap point
		directed.push_back(scan_row(4'd2, 1, 0, 1, 0, 0, 32'hFFFF_FFFF, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd2, 1, 0, 0, 0, 0, 32'h00B7_1AFE, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd2, 1, 0, 0, 0, 0, 32'h00B7_1AFF, 1, ON_LVL_RST));
		directed.push_back(scan_row(4'd2, 0, 0, 1, 0, 0, 32'h00B7_1B00, 1, 8'd0));
		directed.push_back(scan_row(DAC_CHANNEL, 1, 1, 0, 0, 1, 32'd300, 1, ON_LVL_RST));
		directed.push_back(scan_row(DAC_CHANNEL, 1, 1, 0, 0, 0, 32'd301, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd9, 1, 1, 1, 1, 1, 32'hFFFF_FFFF, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd15, 1, 1, 1, 1, 1, 32'hFFFF_FFFF, 1, 8'd0));
		directed.push_back(scan_row(4'd10, 1, 1, 0, 0, 0, 32'd7, 1, 8'd0));
		directed.push_back(scan_row(4'd7, 1, 0, 0, 0, 0, 32'd8, 1, 8'd0));
		// zero hold: bright lasts until the next scan of the channel
		directed.push_back(cfg_row(REG_BRIGHT_HOLD, 32'd0));
		directed.push_back(scan_row(4'd3, 1, 1, 0, 0, 0, 32'd5, 1, BRIGHT_LVL_RST));
		directed.push_back(scan_row(4'd3, 1, 0, 0, 0, 0, 32'd5, 1, ON_LVL_RST));
		directed.push_back(scan_row(4'd3, 1, 1, 0, 0, 0, 32'd6, 1, BRIGHT_LVL_RST));
		// everything masked: square channels still lit
		directed.push_back(cfg_row(REG_ENABLE_MASK, 32'd0));
		directed.push_back(scan_row(4'd3, 1, 1, 0, 0, 0, 32'd9, 1, 8'd0));
		directed.push_back(scan_row(4'd8, 1, 1, 0, 0, 0, 32'd9, 1, BRIGHT_LVL_RST));
		// only the DAC enable bit set
		directed.push_back(cfg_row(REG_ENABLE_MASK, 32'd64));
		directed.push_back(scan_row(DAC_CHANNEL, 1, 0, 0, 0, 1, 32'd10, 1, ON_LVL_RST));
		directed.push_back(scan_row(DAC_CHANNEL, 1, 1, 0, 0, 0, 32'd11, 1, 8'd0));

		// known values on every input before reset lifts
		scan_ch.valid = 1'b0;
		scan_ch.channel = '0;
		scan_ch.key_on = 1'b0;
		scan_ch.key_on_pulse = 1'b0;
		scan_ch.param_pulse = 1'b0;
		scan_ch.fixed_on = 1'b0;
		scan_ch.dac_mode = 1'b0;
		scan_ch.now = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE_MASK;
		cfg_data = '0;
		err_cnt = 0;
		cycles = 0;
		stamp = '0;
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		long_stall_req = 1'b0;
		for (int c = 0; c < NCH; c++) begin
			mode_tbl[c] = MODE_OFF;
			start_tbl[c] = '0;
		end
		mask_cfg = MASK_RST;
		hold_cfg = HOLD_RST;
		bright_cfg = BRIGHT_LVL_RST;
		on_cfg = ON_LVL_RST;

		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int k = 0; k < directed.size(); k++) begin
			if (directed[k].is_cfg) begin
				settle();
				write_reg(directed[k].idx, directed[k].data);
			end else begin
				send_scan(directed[k].s, directed[k].chk, directed[k].lvl);
			end
		end

		// random phases, one register setting each
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_ENABLE_MASK, CFG_W'(ph_mask[p]));
			write_reg(REG_BRIGHT_HOLD, ph_hold[p]);
			write_reg(REG_BRIGHT_LVL, CFG_W'(ph_bright[p]));
			write_reg(REG_ON_LVL, CFG_W'(ph_on[p]));
			stamp = $urandom();
			for (int n = 0; n < PH_ITEMS; n++) begin
				if (n % 32 == 0) begin
					tx_no_idle = ($urandom_range(0, 3) == 0);
					rx_no_idle = ($urandom_range(0, 3) == 0);
				end
				// back-pressure: receiver holds off while scans keep coming
				if (p == 2 && n == 0) begin
					long_stall_req = 1'b1;
					tx_no_idle = 1'b1;
				end
				if (n == 80)
					settle();
				make_scan(s);
				send_scan(s, 1'b0, '0);
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/caled_pkg.sv
src/caled_scan_if.sv
src/caled_level_if.sv
src/caled_update.sv
src/channel_activity_led_state.sv
src/caled_checker.sv
test/channel_activity_led_state_tb.sv
